// ===== sv/ddc_pkg.sv =====
// ---------------------------------------------------------------------------
// ddc_pkg
// Shared types, constants and table functions of the date / day count
// converter.
// ---------------------------------------------------------------------------
package ddc_pkg;

    localparam int COUNT_BITS = 20;
    localparam int YEAR_BITS  = 12;
    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;
    localparam int OFS_BITS   = 20;
    localparam int YS_BITS    = 21;
    localparam int ACC_BITS   = 22;

    localparam logic [YEAR_BITS-1:0] EPOCH_RESET  = 12'd1970;
    localparam logic [10:0]          DAYS_CYCLE   = 11'd1461;
    localparam logic [8:0]           DAYS_COMMON  = 9'd365;
    localparam logic [8:0]           DAYS_LEAP    = 9'd366;
    localparam logic [ACC_BITS-1:0]  CYCLE_RECIP  = 22'd2939744;
    localparam int                   RECIP_SHIFT  = 32;
    localparam logic [12:0]          YEAR_LIMIT   = 13'd4095;

    typedef enum logic [1:0] {
        CMD_TO_COUNT   = 2'd0,
        CMD_TO_DATE    = 2'd1,
        CMD_ADD_OFFSET = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic [DAY_BITS-1:0]         day;
        logic [MONTH_BITS-1:0]       month;
        logic [YEAR_BITS-1:0]        year;
        logic [COUNT_BITS-1:0]       day_count_in;
        logic signed [OFS_BITS-1:0]  day_offset;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]       day_count_out;
        logic [DAY_BITS-1:0]         out_day;
        logic [MONTH_BITS-1:0]       out_month;
        logic [YEAR_BITS-1:0]        out_year;
        logic                        range_error;
    } out_item_t;

    localparam logic [8:0] CUM_COMMON [12] =
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
    localparam logic [8:0] CUM_LEAP [12] =
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
          9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

    // Days before the first of the month, month index 0 is January.
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
        return leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
    endfunction

    // Days from January 1st of year 0 to January 1st of year y.
    function automatic logic [YS_BITS-1:0] year_start(input logic [YEAR_BITS-1:0] y);
        return YS_BITS'(y) * YS_BITS'(DAYS_COMMON)
             + YS_BITS'((13'(y) + 13'd3) >> 2);
    endfunction

endpackage

// ===== sv/ddc_month.sv =====
// ---------------------------------------------------------------------------
// ddc_month
// Finds the month and day of month of a day of year by comparing it against
// the cumulative month table of a common or a leap year.
// ---------------------------------------------------------------------------
module ddc_month
    import ddc_pkg::*;
(
    input  logic                  leap,
    input  logic [8:0]            doy,
    output logic [MONTH_BITS-1:0] month,
    output logic [DAY_BITS-1:0]   day
);

    logic [3:0] m;
    logic [8:0] base;
    logic [8:0] dom;

    always_comb
    begin
        m    = 4'd12;
        base = cum_days(leap, 4'd11);
        for (int i = 11; i >= 1; i--)
        begin
            if (cum_days(leap, 4'(i)) > doy)
            begin
                m    = 4'(i);
                base = cum_days(leap, 4'(i - 1));
            end
        end
        dom = doy - base + 9'd1;
    end

    assign month = m;
    assign day   = dom[DAY_BITS-1:0];

endmodule

// ===== sv/date_day_count_converter.sv =====
// ---------------------------------------------------------------------------
// date_day_count_converter
// Pipelined converter between calendar dates and day counts from an epoch.
// ---------------------------------------------------------------------------
// Usage:
// Input items arrive on in_valid / in_stall / in_data and results leave on
// out_valid / out_stall / out_data. An item moves at a clock edge where valid
// is high and stall is low. Every input item gives exactly one result item.
// The epoch year is written through cfg_we / cfg_data while no item is in
// flight; the new value applies to items accepted from the next cycle on.
// An accepted item passes through six register stages, the first of which
// loads at the accepting edge: date count, epoch offset, reciprocal
// multiply, cycle remainder, year split and month lookup.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its item and the
// stages behind it keep filling empty slots; in_stall rises only when every
// stage holds an item. Reset clears all valid bits and sets the epoch year
// to 1970.
// ---------------------------------------------------------------------------
module date_day_count_converter
    import ddc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [YEAR_BITS-1:0] cfg_data
);

    logic [YEAR_BITS-1:0] epoch_reg;
    logic [YS_BITS-1:0]   ys_e_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // Stage 1: day count of the input date from year 0.
    cmd_t                       s1_cmd_reg;
    logic signed [ACC_BITS-1:0] s1_date_reg;
    logic [COUNT_BITS-1:0]      s1_cin_reg;
    logic signed [OFS_BITS-1:0] s1_off_reg;
    logic signed [ACC_BITS-1:0] s1_date_next;
    logic [3:0]                 s1_mi;
    logic                       s1_leap;

    // Stage 2: count against the epoch and absolute day number.
    logic [ACC_BITS-1:0]        s2_a_reg;
    logic [COUNT_BITS-1:0]      s2_n_reg;
    logic                       s2_err_reg;
    logic signed [23:0]         s2_a_date;
    logic signed [23:0]         s2_c;
    logic [ACC_BITS-1:0]        s2_a_next;
    logic [COUNT_BITS-1:0]      s2_n_next;
    logic                       s2_err_next;

    // Stage 3: estimated four-year cycle number.
    logic [ACC_BITS-1:0]        s3_a_reg;
    logic [COUNT_BITS-1:0]      s3_n_reg;
    logic                       s3_err_reg;
    logic [11:0]                s3_q_reg;
    logic [2*ACC_BITS-1:0]      s3_prod;

    // Stage 4: remainder within the cycle, off by at most one cycle.
    logic [11:0]                s4_q_reg;
    logic [11:0]                s4_r_reg;
    logic [COUNT_BITS-1:0]      s4_n_reg;
    logic                       s4_err_reg;
    logic [ACC_BITS-1:0]        s4_r_full;

    // Stage 5: year and day of year.
    logic [YEAR_BITS-1:0]       s5_y_reg;
    logic [8:0]                 s5_doy_reg;
    logic                       s5_leap_reg;
    logic [COUNT_BITS-1:0]      s5_n_reg;
    logic                       s5_err_reg;
    logic [11:0]                s5_q;
    logic [10:0]                s5_r;
    logic [10:0]                s5_t;
    logic [1:0]                 s5_yo;
    logic [8:0]                 s5_doy;
    logic [12:0]                s5_y;

    // Stage 6: output register.
    out_item_t                  out_data_reg;
    out_item_t                  out_data_next;
    logic [MONTH_BITS-1:0]      s6_month;
    logic [DAY_BITS-1:0]        s6_day;

    assign en6      = !v6_reg || !out_stall;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RESET;
            ys_e_reg  <= year_start(EPOCH_RESET);
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                epoch_reg <= cfg_data;
            end
            ys_e_reg <= year_start(epoch_reg);
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_comb
    begin
        if (in_data.month == 4'd0)
        begin
            s1_mi = 4'd0;
        end
        else if (in_data.month > 4'd12)
        begin
            s1_mi = 4'd11;
        end
        else
        begin
            s1_mi = in_data.month - 4'd1;
        end
        s1_leap      = (in_data.year[1:0] == 2'b00);
        s1_date_next = $signed(ACC_BITS'(year_start(in_data.year)))
                     + $signed(ACC_BITS'(cum_days(s1_leap, s1_mi)))
                     + $signed(ACC_BITS'(in_data.day))
                     - $signed(ACC_BITS'(1));
    end

    always_comb
    begin
        s2_a_date = 24'(s1_date_reg);
        if (s1_cmd_reg == CMD_ADD_OFFSET)
        begin
            s2_a_date = 24'(s1_date_reg) + 24'(s1_off_reg);
        end
        s2_c = s2_a_date - $signed(24'(ys_e_reg));
        case (s1_cmd_reg)
            CMD_TO_DATE:
            begin
                s2_n_next   = s1_cin_reg;
                s2_a_next   = ACC_BITS'(s1_cin_reg) + ACC_BITS'(ys_e_reg);
                s2_err_next = 1'b0;
            end
            CMD_TO_COUNT, CMD_ADD_OFFSET:
            begin
                s2_n_next   = s2_c[COUNT_BITS-1:0];
                s2_a_next   = s2_a_date[ACC_BITS-1:0];
                s2_err_next = s2_c[23] || (|s2_c[22:COUNT_BITS]);
            end
            default:
            begin
                s2_n_next   = '0;
                s2_a_next   = '0;
                s2_err_next = 1'b1;
            end
        endcase
    end

    assign s3_prod   = (2*ACC_BITS)'(s2_a_reg) * (2*ACC_BITS)'(CYCLE_RECIP);
    assign s4_r_full = s3_a_reg - ACC_BITS'(s3_q_reg) * ACC_BITS'(DAYS_CYCLE);

    always_comb
    begin
        if (s4_r_reg >= 12'(DAYS_CYCLE))
        begin
            s5_r = 11'(s4_r_reg - 12'(DAYS_CYCLE));
            s5_q = s4_q_reg + 12'd1;
        end
        else
        begin
            s5_r = s4_r_reg[10:0];
            s5_q = s4_q_reg;
        end
        s5_t = s5_r - 11'(DAYS_LEAP);
        if (s5_r < 11'(DAYS_LEAP))
        begin
            s5_yo  = 2'd0;
            s5_doy = s5_r[8:0];
        end
        else if (s5_t >= 11'(2 * DAYS_COMMON))
        begin
            s5_yo  = 2'd3;
            s5_doy = 9'(s5_t - 11'(2 * DAYS_COMMON));
        end
        else if (s5_t >= 11'(DAYS_COMMON))
        begin
            s5_yo  = 2'd2;
            s5_doy = 9'(s5_t - 11'(DAYS_COMMON));
        end
        else
        begin
            s5_yo  = 2'd1;
            s5_doy = s5_t[8:0];
        end
        s5_y = {s5_q[10:0], 2'b00} + 13'(s5_yo);
    end

    ddc_month u_month
    (
        .leap  (s5_leap_reg),
        .doy   (s5_doy_reg),
        .month (s6_month),
        .day   (s6_day)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next.range_error = s5_err_reg;
        if (!s5_err_reg)
        begin
            out_data_next.day_count_out = s5_n_reg;
            out_data_next.out_day       = s6_day;
            out_data_next.out_month     = s6_month;
            out_data_next.out_year      = s5_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_cmd_reg  <= in_data.cmd;
            s1_date_reg <= s1_date_next;
            s1_cin_reg  <= in_data.day_count_in;
            s1_off_reg  <= in_data.day_offset;
        end
        if (en2)
        begin
            s2_a_reg   <= s2_a_next;
            s2_n_reg   <= s2_n_next;
            s2_err_reg <= s2_err_next;
        end
        if (en3)
        begin
            s3_a_reg   <= s2_a_reg;
            s3_n_reg   <= s2_n_reg;
            s3_err_reg <= s2_err_reg;
            s3_q_reg   <= s3_prod[RECIP_SHIFT+11:RECIP_SHIFT];
        end
        if (en4)
        begin
            s4_q_reg   <= s3_q_reg;
            s4_r_reg   <= s4_r_full[11:0];
            s4_n_reg   <= s3_n_reg;
            s4_err_reg <= s3_err_reg;
        end
        if (en5)
        begin
            s5_y_reg    <= s5_y[YEAR_BITS-1:0];
            s5_doy_reg  <= s5_doy;
            s5_leap_reg <= (s5_yo == 2'd0);
            s5_n_reg    <= s4_n_reg;
            s5_err_reg  <= s4_err_reg || (s5_y > YEAR_LIMIT);
        end
        if (en6)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/ddc_checker.sv =====
// ---------------------------------------------------------------------------
// ddc_checker
// Port-level checks of the date / day count converter, bound to the top.
// ---------------------------------------------------------------------------
module ddc_checker
    import ddc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_error |->
            out_data.day_count_out == '0 && out_data.out_day == '0 &&
            out_data.out_month == '0 && out_data.out_year == '0)
        else $error("error item carries nonzero fields");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.range_error |->
            out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12 &&
            out_data.out_day >= 5'd1 && out_data.out_day <= 5'd31)
        else $error("decoded date out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

endmodule

bind date_day_count_converter ddc_checker u_ddc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== verif/date_day_count_converter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// date_day_count_converter_tb
// Self-checking testbench for the date / day count converter. A short
// directed pass hits the range limits and odd dates. Random traffic then runs
// under several epoch years, in some phases with random idling on both sides.
// Results are checked field by field against a table row or behavioral model.
// ---------------------------------------------------------------------------
module date_day_count_converter_tb;
    import ddc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 110;
    localparam int NUM_PHASES   = 6;

    localparam int MONTH_START [2][12] = '{
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
        '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}
    };

    localparam out_item_t RANGE_ERR_RESULT = '{20'd0, 5'd0, 4'd0, 12'd0, 1'b1};
    localparam out_item_t NO_LITERAL       = '0;

    typedef struct packed {
        in_item_t  stim;
        logic      has_literal;
        out_item_t literal;
    } directed_row_t;

    localparam int NUM_DIRECTED = 21;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{CMD_TO_COUNT, 5'd1, 4'd1, 12'd1970, 20'd0, 20'h0}, 1'b1,
          '{20'd0, 5'd1, 4'd1, 12'd1970, 1'b0}},
        '{'{CMD_TO_DATE, 5'd0, 4'd0, 12'd0, 20'd0, 20'h0}, 1'b1,
          '{20'd0, 5'd1, 4'd1, 12'd1970, 1'b0}},
        '{'{CMD_TO_COUNT, 5'd31, 4'd12, 12'd1969, 20'd0, 20'h0}, 1'b1, RANGE_ERR_RESULT},
        '{'{CMD_TO_COUNT, 5'd1, 4'd1, 12'd0, 20'd0, 20'h0}, 1'b1, RANGE_ERR_RESULT},
        '{'{CMD_UNUSED, 5'd31, 4'd15, 12'd4095, 20'hFFFFF, 20'hFFFFF}, 1'b1,
          RANGE_ERR_RESULT},
        '{'{CMD_ADD_OFFSET, 5'd1, 4'd1, 12'd1970, 20'd0, 20'hFFFFF}, 1'b1,
          RANGE_ERR_RESULT},
        '{'{CMD_TO_DATE, 5'd0, 4'd0, 12'd0, 20'hFFFFF, 20'h0}, 1'b1, RANGE_ERR_RESULT},
        '{'{CMD_ADD_OFFSET, 5'd31, 4'd12, 12'd4095, 20'd0, 20'h7FFFF}, 1'b1,
          RANGE_ERR_RESULT},
        '{'{CMD_TO_COUNT, 5'd31, 4'd12, 12'd4095, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd1, 4'd1, 12'd4095, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd29, 4'd2, 12'd2000, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd0, 4'd3, 12'd2000, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd31, 4'd2, 12'd1971, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd15, 4'd0, 12'd1980, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd15, 4'd15, 12'd1980, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_COUNT, 5'd31, 4'd4, 12'd2023, 20'd0, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_DATE, 5'd0, 4'd0, 12'd0, 20'd365, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_TO_DATE, 5'd0, 4'd0, 12'd0, 20'h80000, 20'h0}, 1'b0, NO_LITERAL},
        '{'{CMD_ADD_OFFSET, 5'd1, 4'd1, 12'd1970, 20'd0, 20'h7FFFF}, 1'b0, NO_LITERAL},
        '{'{CMD_ADD_OFFSET, 5'd31, 4'd12, 12'd4095, 20'd0, 20'h80000}, 1'b0, NO_LITERAL},
        '{'{CMD_ADD_OFFSET, 5'd28, 4'd2, 12'd2024, 20'd0, 20'h1}, 1'b0, NO_LITERAL}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [YEAR_BITS-1:0] cfg_data;

    out_item_t            pending_results [$];
    logic [YEAR_BITS-1:0] epoch_model;
    int                   src_idle_pct;
    int                   dst_stall_pct;
    int                   hold_left;
    int                   mismatch_count;
    int                   items_sent;
    int                   results_seen;
    int                   errors_seen;
    int                   epochs_used;
    int                   cycle_count;

    date_day_count_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint days_to_jan1(input longint y);
        return 365 * y + (y + 3) / 4;
    endfunction

    function automatic longint count_of_date(input in_item_t it, input logic [YEAR_BITS-1:0] ep);
        int  mi;
        int  leap;
        leap = (it.year[1:0] == 2'b00) ? 1 : 0;
        if (it.month == 4'd0)
            mi = 0;
        else if (it.month > 4'd12)
            mi = 11;
        else
            mi = int'(it.month) - 1;
        return days_to_jan1(longint'(it.year)) + MONTH_START[leap][mi]
             + longint'(it.day) - 1 - days_to_jan1(longint'(ep));
    endfunction

    function automatic out_item_t convert_date(input in_item_t it,
                                               input logic [YEAR_BITS-1:0] ep);
        longint    cnt;
        longint    abs_days;
        longint    rem;
        longint    yoff;
        longint    doy;
        longint    yr;
        int        leap;
        int        mon;
        bit        ok;
        out_item_t res;
        ok  = 1'b1;
        cnt = 0;
        res = '0;
        case (it.cmd)
            CMD_TO_COUNT:   cnt = count_of_date(it, ep);
            CMD_TO_DATE:    cnt = longint'(it.day_count_in);
            CMD_ADD_OFFSET: cnt = count_of_date(it, ep) + longint'($signed(it.day_offset));
            default:        ok = 1'b0;
        endcase
        if (ok && (cnt < 0 || cnt > (longint'(1) << COUNT_BITS) - 1))
            ok = 1'b0;
        if (ok)
        begin
            abs_days = cnt + days_to_jan1(longint'(ep));
            rem      = abs_days % 1461;
            if (rem < 366)
            begin
                yoff = 0;
                doy  = rem;
            end
            else
            begin
                yoff = 1 + (rem - 366) / 365;
                doy  = (rem - 366) % 365;
            end
            yr = 4 * (abs_days / 1461) + yoff;
            if (yr > 4095)
                ok = 1'b0;
            leap = (yoff == 0) ? 1 : 0;
            mon  = 12;
            for (int i = 1; i < 12; i++)
            begin
                if (MONTH_START[leap][i] > doy)
                begin
                    mon = i;
                    break;
                end
            end
            res.day_count_out = cnt[COUNT_BITS-1:0];
            res.out_day       = DAY_BITS'(doy - MONTH_START[leap][mon-1] + 1);
            res.out_month     = MONTH_BITS'(mon);
            res.out_year      = YEAR_BITS'(yr);
        end
        if (!ok)
            res = RANGE_ERR_RESULT;
        return res;
    endfunction

    function automatic in_item_t random_item(input logic [YEAR_BITS-1:0] ep);
        in_item_t it;
        int       ymax;
        int       cmax;
        it = in_item_t'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 85)
        begin
            ymax = (int'(ep) + 2800 > 4095) ? 4095 : int'(ep) + 2800;
            cmax = (ymax - int'(ep) + 1) * 366;
            if (cmax > 1048575)
                cmax = 1048575;
            it.cmd   = cmd_t'($urandom_range(0, 2));
            it.year  = YEAR_BITS'($urandom_range(int'(ep), ymax));
            it.month = MONTH_BITS'($urandom_range(1, 12));
            it.day   = ($urandom_range(0, 9) == 0) ? DAY_BITS'($urandom_range(0, 31))
                                                   : DAY_BITS'($urandom_range(1, 28));
            it.day_count_in = COUNT_BITS'($urandom_range(0, cmax));
            if ($urandom_range(0, 7) != 0)
                it.day_offset = OFS_BITS'(int'($urandom_range(0, 8000)) - 4000);
        end
        return it;
    endfunction

    // The item stays on the bus after acceptance; the next call replaces it
    // in the same time step or drops valid.
    task automatic send_item(input in_item_t it, input out_item_t predicted);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_epoch(input logic [YEAR_BITS-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        epoch_model = value;
        epochs_used++;
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (out_data.range_error)
                    errors_seen++;
                if (out_data.day_count_out !== exp_res.day_count_out)
                    $display("%0t: day_count_out expected %0d actual %0d", $time,
                             exp_res.day_count_out, out_data.day_count_out);
                if (out_data.out_day !== exp_res.out_day)
                    $display("%0t: out_day expected %0d actual %0d", $time,
                             exp_res.out_day, out_data.out_day);
                if (out_data.out_month !== exp_res.out_month)
                    $display("%0t: out_month expected %0d actual %0d", $time,
                             exp_res.out_month, out_data.out_month);
                if (out_data.out_year !== exp_res.out_year)
                    $display("%0t: out_year expected %0d actual %0d", $time,
                             exp_res.out_year, out_data.out_year);
                if (out_data.range_error !== exp_res.range_error)
                    $display("%0t: range_error expected %0b actual %0b", $time,
                             exp_res.range_error, out_data.range_error);
                if (out_data !== exp_res)
                    mismatch_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        epoch_model    = EPOCH_RESET;
        src_idle_pct   = 0;
        dst_stall_pct  = 0;
        hold_left      = 0;
        mismatch_count = 0;
        items_sent     = 0;
        results_seen   = 0;
        errors_seen    = 0;
        epochs_used    = 1;
        cycle_count    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].has_literal ?
                      DIRECTED_ROWS[i].literal :
                      convert_date(DIRECTED_ROWS[i].stim, epoch_model));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       write_epoch(12'd0);
                1:       write_epoch(12'd4095);
                5:       write_epoch(EPOCH_RESET);
                default: write_epoch(YEAR_BITS'($urandom_range(0, 4095)));
            endcase
            src_idle_pct  = (p < 2) ? 33 : (p < 4) ? 51 : 0;
            dst_stall_pct = (p < 2) ? 51 : (p < 4) ? 33 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == PHASE_ITEMS / 2)
                    wait_drained();
                it = random_item(epoch_model);
                send_item(it, convert_date(it, epoch_model));
            end
        end

        // Long receiver hold-off with a busy sender, so the pipeline backs up.
        hold_left = 80;
        for (int i = 0; i < 40; i++)
        begin
            it = random_item(epoch_model);
            send_item(it, convert_date(it, epoch_model));
        end

        wait_drained();
        if (pending_results.size() != 0)
            mismatch_count++;
        $display("Sent %0d items over %0d epoch settings; %0d results checked, %0d range errors.",
                 items_sent, epochs_used, results_seen, errors_seen);
        $display("Mismatching results: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
